>>> hdl/cdr_pkg.sv
// shared types, constants and helpers of the character display raster
package cdr_pkg;

    localparam int COLUMNS            = 80;
    localparam int TEXT_ROWS          = 16;
    localparam int LINES_PER_ROW      = 10;
    localparam int VIDEO_SIZE         = 1280;
    localparam int GLYPH_SIZE         = 512;
    localparam int FIRST_BLANK_BOTTOM = 9;

    localparam int VIDEO_AW  = $clog2(VIDEO_SIZE);
    localparam int GLYPH_AW  = $clog2(GLYPH_SIZE);
    localparam int CHAR_W    = 6;
    localparam int GLYPH_W   = 8;
    localparam int COL_W     = 7;
    localparam int LINE_W    = 4;
    localparam int ROW_W     = 4;
    localparam int SCAN_W    = 8;
    localparam int ADDR_W    = 11;
    localparam int DATA_W    = 8;
    localparam int START_W   = 11;
    localparam int SUB_LINE_W = 3;

    typedef enum logic [1:0] {
        OP_VIDEO_WR = 2'd0,
        OP_GLYPH_WR = 2'd1,
        OP_TICK     = 2'd2
    } cdr_op_t;

    // write port of the video store
    typedef struct packed {
        logic                en;
        logic [VIDEO_AW-1:0] addr;
        logic [CHAR_W-1:0]   data;
    } cdr_vid_wr_t;

    // write port of the glyph store
    typedef struct packed {
        logic                en;
        logic [GLYPH_AW-1:0] addr;
        logic [GLYPH_W-1:0]  data;
    } cdr_gly_wr_t;

    // position of one cell tick as it travels down the pipeline
    typedef struct packed {
        logic [COL_W-1:0]      column;
        logic [SCAN_W-1:0]     scanline;
        logic                  frame_end;
        logic                  lit;
        logic [SUB_LINE_W-1:0] sub_line;
    } cdr_tick_t;

    // new bits 5..0 are old bits 2,1,0,3,4,5
    function automatic logic [CHAR_W-1:0] permute_code(input logic [CHAR_W-1:0] c);
        permute_code = {c[2], c[1], c[0], c[3], c[4], c[5]};
    endfunction

endpackage

>>> hdl/character_display_raster_top.sv
// top level of the character display raster generator
//
// input channel s_*: each item writes a character code into the video store
// (opcode 0, low 6 data bits kept), writes a pixel byte into the glyph store
// (opcode 1), or ticks one cell (opcode 2). opcode 3 is taken and dropped.
// only a tick makes an item on the result channel m_*: column, scanline,
// eight pixels (bit 7 leftmost) and a frame_end flag on the last cell.
// cfg_* writes the display start offset; it is always ready.
//
// a tick runs through two chained registered memory reads, video store then
// glyph store, and an output register. while s_ready is high the pipeline
// takes one item per cycle, so the sustained rate is one item a cycle, set by
// the single read port of each store.
//
// after reset both stores are swept to zero, one entry a cycle over the 1280
// video entries (the glyph store is cleared in the first 512 of them); s_ready
// stays low until the sweep is done. when m_ready is low the output register
// holds, the two read stages behind it fill, and then s_ready falls.
module character_display_raster_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdr_pkg::START_W-1:0]       cfg_data,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic [cdr_pkg::ADDR_W-1:0]        s_address,
    input  logic [cdr_pkg::DATA_W-1:0]        s_data,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [cdr_pkg::COL_W-1:0]         m_column,
    output logic [cdr_pkg::SCAN_W-1:0]        m_scanline,
    output logic [cdr_pkg::GLYPH_W-1:0]       m_pixels,
    output logic                              m_frame_end
);
    import cdr_pkg::*;

    // clearing sweep after reset
    logic                clr_active_reg, clr_active_next;
    logic [VIDEO_AW-1:0] clr_cnt_reg,    clr_cnt_next;

    // pipeline stage a: video read in flight
    logic      a_valid_reg, a_valid_next;
    cdr_tick_t a_tick_reg;
    // pipeline stage b: glyph read in flight
    logic      b_valid_reg, b_valid_next;
    cdr_tick_t b_tick_reg;
    // output register
    logic               m_valid_reg, m_valid_next;
    logic [COL_W-1:0]   m_column_reg;
    logic [SCAN_W-1:0]  m_scanline_reg;
    logic [GLYPH_W-1:0] m_pixels_reg;
    logic               m_frame_end_reg;

    logic accept;
    logic tick_acc;
    logic vid_we;
    logic gly_we;
    logic out_ready;
    logic b_ready;
    logic a_ready;
    logic a_move;
    logic b_move;

    cdr_tick_t           cur_tick;
    logic [VIDEO_AW-1:0] video_addr;
    logic [CHAR_W-1:0]   vid_q;
    logic [GLYPH_W-1:0]  gly_q;
    cdr_vid_wr_t         vid_wr;
    cdr_gly_wr_t         gly_wr;

    // handshake chain: each stage moves when the one after it has room
    assign out_ready = !m_valid_reg || m_ready;
    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign a_move    = a_valid_reg && b_ready;
    assign b_move    = b_valid_reg && out_ready;

    // every item waits for stage a to have room, so a glyph write never
    // lands ahead of the glyph read of an earlier tick
    assign s_ready   = !clr_active_reg && a_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        tick_acc = 1'b0;
        vid_we   = 1'b0;
        gly_we   = 1'b0;
        case (s_opcode)
            OP_VIDEO_WR: vid_we   = accept && (s_address < ADDR_W'(VIDEO_SIZE));
            OP_GLYPH_WR: gly_we   = accept && (s_address < ADDR_W'(GLYPH_SIZE));
            OP_TICK:     tick_acc = accept;
            default:     tick_acc = 1'b0;
        endcase
    end

    // store write ports: the clearing sweep owns them until it is done
    always_comb begin
        if (clr_active_reg) begin
            vid_wr.en   = 1'b1;
            vid_wr.addr = clr_cnt_reg;
            vid_wr.data = '0;
            gly_wr.en   = (clr_cnt_reg < VIDEO_AW'(GLYPH_SIZE));
            gly_wr.addr = GLYPH_AW'(clr_cnt_reg);
            gly_wr.data = '0;
        end else begin
            vid_wr.en   = vid_we;
            vid_wr.addr = VIDEO_AW'(s_address);
            vid_wr.data = s_data[CHAR_W-1:0];
            gly_wr.en   = gly_we;
            gly_wr.addr = GLYPH_AW'(s_address);
            gly_wr.data = s_data;
        end
    end

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg) begin
            if (clr_cnt_reg == VIDEO_AW'(VIDEO_SIZE - 1)) begin
                clr_active_next = 1'b0;
            end else begin
                clr_cnt_next = clr_cnt_reg + VIDEO_AW'(1);
            end
        end
    end

    // valid bits of the stages
    always_comb begin
        a_valid_next = a_valid_reg;
        if (tick_acc) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (a_move) begin
            b_valid_next = 1'b1;
        end else if (b_move) begin
            b_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (b_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    cdr_raster u_raster (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .advance    (tick_acc),
        .tick       (cur_tick),
        .video_addr (video_addr)
    );

    // video read issued with the tick, data lines up with stage a
    cdr_video_store u_video_store (
        .aclk    (aclk),
        .wr      (vid_wr),
        .rd_en   (tick_acc),
        .rd_addr (video_addr),
        .rd_data (vid_q)
    );

    // glyph read issued as stage a moves on, data lines up with stage b
    cdr_glyph_store u_glyph_store (
        .aclk    (aclk),
        .wr      (gly_wr),
        .rd_en   (a_move),
        .rd_char (vid_q),
        .rd_line (a_tick_reg.sub_line),
        .rd_data (gly_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            a_tick_reg <= cur_tick;
        end
        if (a_move) begin
            b_tick_reg <= a_tick_reg;
        end
        if (b_move) begin
            m_column_reg    <= b_tick_reg.column;
            m_scanline_reg  <= b_tick_reg.scanline;
            m_frame_end_reg <= b_tick_reg.frame_end;
            // blank lines give no pixels
            m_pixels_reg    <= b_tick_reg.lit ? gly_q : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_column    = m_column_reg;
    assign m_scanline  = m_scanline_reg;
    assign m_pixels    = m_pixels_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

>>> hdl/cdr_video_store.sv
// video store: character codes, one write port and one registered read port
module cdr_video_store (
    input  logic                                 aclk,
    input  cdr_pkg::cdr_vid_wr_t                 wr,
    input  logic                                 rd_en,
    input  logic [cdr_pkg::VIDEO_AW-1:0]         rd_addr,
    output logic [cdr_pkg::CHAR_W-1:0]           rd_data
);
    import cdr_pkg::*;

    logic [CHAR_W-1:0] mem [VIDEO_SIZE];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/cdr_glyph_store.sv
// glyph store: pixel rows of the character set, registered read port
module cdr_glyph_store (
    input  logic                                 aclk,
    input  cdr_pkg::cdr_gly_wr_t                 wr,
    input  logic                                 rd_en,
    input  logic [cdr_pkg::CHAR_W-1:0]           rd_char,
    input  logic [cdr_pkg::SUB_LINE_W-1:0]       rd_line,
    output logic [cdr_pkg::GLYPH_W-1:0]          rd_data
);
    import cdr_pkg::*;

    logic [GLYPH_W-1:0]  mem [GLYPH_SIZE];
    logic [GLYPH_W-1:0]  rd_data_reg;
    logic [GLYPH_AW-1:0] rd_addr;

    // permuted code selects the glyph, sub line the row within it
    assign rd_addr = {permute_code(rd_char), rd_line};

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/cdr_raster.sv
// raster position counters, start offset register and video address
module cdr_raster (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [cdr_pkg::START_W-1:0]          cfg_data,
    input  logic                                 advance,
    output cdr_pkg::cdr_tick_t                   tick,
    output logic [cdr_pkg::VIDEO_AW-1:0]         video_addr
);
    import cdr_pkg::*;

    localparam int SUM_W = VIDEO_AW + 1;

    logic [COL_W-1:0]   col_reg,   col_next;
    logic [LINE_W-1:0]  line_reg,  line_next;
    logic [ROW_W-1:0]   row_reg,   row_next;
    logic [SCAN_W-1:0]  scan_reg,  scan_next;
    logic [START_W-1:0] start_reg, start_next;

    logic             col_last;
    logic             line_last;
    logic             row_last;
    logic [SUM_W-1:0] addr_sum;

    assign col_last  = (col_reg == COL_W'(COLUMNS - 1));
    assign line_last = (line_reg == LINE_W'(LINES_PER_ROW - 1));
    assign row_last  = (row_reg == ROW_W'(TEXT_ROWS - 1));

    // start is kept reduced below the store size, so one subtract suffices
    assign addr_sum = SUM_W'(start_reg) + SUM_W'(row_reg) + {1'b0, col_reg, 4'b0000};

    always_comb begin
        if (addr_sum >= SUM_W'(VIDEO_SIZE)) begin
            video_addr = VIDEO_AW'(addr_sum - SUM_W'(VIDEO_SIZE));
        end else begin
            video_addr = VIDEO_AW'(addr_sum);
        end
    end

    always_comb begin
        tick.column    = col_reg;
        tick.scanline  = scan_reg;
        tick.frame_end = col_last && line_last && row_last;
        tick.lit       = (line_reg != '0) && (line_reg < LINE_W'(FIRST_BLANK_BOTTOM));
        tick.sub_line  = SUB_LINE_W'(line_reg - LINE_W'(1));
    end

    always_comb begin
        start_next = start_reg;
        if (cfg_we) begin
            if (cfg_data >= START_W'(VIDEO_SIZE)) begin
                start_next = cfg_data - START_W'(VIDEO_SIZE);
            end else begin
                start_next = cfg_data;
            end
        end
    end

    always_comb begin
        col_next  = col_reg;
        line_next = line_reg;
        row_next  = row_reg;
        scan_next = scan_reg;
        if (advance) begin
            if (!col_last) begin
                col_next = col_reg + COL_W'(1);
            end else begin
                col_next  = '0;
                scan_next = scan_reg + SCAN_W'(1);
                if (!line_last) begin
                    line_next = line_reg + LINE_W'(1);
                end else begin
                    line_next = '0;
                    if (!row_last) begin
                        row_next = row_reg + ROW_W'(1);
                    end else begin
                        row_next  = '0;
                        scan_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            line_reg  <= '0;
            row_reg   <= '0;
            scan_reg  <= '0;
            start_reg <= '0;
        end else begin
            col_reg   <= col_next;
            line_reg  <= line_next;
            row_reg   <= row_next;
            scan_reg  <= scan_next;
            start_reg <= start_next;
        end
    end

endmodule

>>> dv/cdr_raster_checker.sv
// checker for the character display raster: predicts every cell item and compares results
module cdr_raster_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [cdr_pkg::START_W-1:0] cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [cdr_pkg::ADDR_W-1:0]  s_address,
    input  logic [cdr_pkg::DATA_W-1:0]  s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [cdr_pkg::COL_W-1:0]   m_column,
    input  logic [cdr_pkg::SCAN_W-1:0]  m_scanline,
    input  logic [cdr_pkg::GLYPH_W-1:0] m_pixels,
    input  logic                        m_frame_end,
    output int unsigned                 mismatch_count,
    output int unsigned                 pending_cells
);
    import cdr_pkg::*;

    localparam int CELL_STRIDE = 16;
    localparam int PRINT_CAP   = 200;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [SCAN_W-1:0]  scanline;
        logic [GLYPH_W-1:0] pixels;
        logic               frame_end;
    } cell_item_t;

    logic [CHAR_W-1:0]  char_mem [VIDEO_SIZE];
    logic [GLYPH_W-1:0] font_mem [GLYPH_SIZE];
    logic [COL_W-1:0]   col_q;
    logic [LINE_W-1:0]  line_q;
    logic [ROW_W-1:0]   row_q;
    logic [START_W-1:0] start_q;
    cell_item_t         cell_queue [$];
    int unsigned        fail_tally = 0;
    int unsigned        cells_seen = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_tally++;
        if (fail_tally <= PRINT_CAP)
            $display("mismatch on cell %0d, %s: got %0d, expected %0d",
                     cells_seen, what, got, want);
    endtask

    task automatic clear_model();
        foreach (char_mem[i]) char_mem[i] = '0;
        foreach (font_mem[i]) font_mem[i] = '0;
        col_q   = '0;
        line_q  = '0;
        row_q   = '0;
        start_q = '0;
    endtask

    // pixels of the current cell, then step the raster
    task automatic tick_cell();
        cell_item_t              pred;
        int unsigned             slot;
        logic [CHAR_W-1:0]       code;
        logic [CHAR_W-1:0]       shuffled;
        logic [SUB_LINE_W-1:0]   sub_line;
        logic [GLYPH_AW-1:0]     font_index;
        pred.pixels = '0;
        if (line_q != 0 && int'(line_q) < FIRST_BLANK_BOTTOM) begin
            slot       = (int'(start_q) + int'(row_q) + int'(col_q) * CELL_STRIDE) % VIDEO_SIZE;
            code       = char_mem[slot];
            shuffled   = {code[2], code[1], code[0], code[3], code[4], code[5]};
            sub_line   = SUB_LINE_W'(line_q - 1'b1);
            font_index = {shuffled, sub_line};
            pred.pixels = font_mem[font_index];
        end
        pred.column    = col_q;
        pred.scanline  = SCAN_W'(int'(row_q) * LINES_PER_ROW + int'(line_q));
        pred.frame_end = (int'(col_q) == COLUMNS - 1) && (int'(line_q) == LINES_PER_ROW - 1)
                         && (int'(row_q) == TEXT_ROWS - 1);
        cell_queue.push_back(pred);

        if (int'(col_q) == COLUMNS - 1) begin
            col_q = '0;
            if (int'(line_q) == LINES_PER_ROW - 1) begin
                line_q = '0;
                row_q  = (int'(row_q) == TEXT_ROWS - 1) ? '0 : row_q + 1'b1;
            end else begin
                line_q = line_q + 1'b1;
            end
        end else begin
            col_q = col_q + 1'b1;
        end
    endtask

    task automatic take_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        case (op)
            OP_VIDEO_WR: begin
                if (addr < VIDEO_SIZE) char_mem[addr] = data[CHAR_W-1:0];
            end
            OP_GLYPH_WR: begin
                if (addr < GLYPH_SIZE) font_mem[addr[GLYPH_AW-1:0]] = data;
            end
            OP_TICK: begin
                tick_cell();
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : watch
        cell_item_t want;
        if (!aresetn) begin
            clear_model();
            cell_queue.delete();
        end else begin
            // a result never belongs to the item taken at the same edge
            if (m_valid && m_ready) begin
                if (cell_queue.size() == 0) begin
                    report_mismatch("cell with none pending, column", m_column, -1);
                end else begin
                    want = cell_queue.pop_front();
                    if (m_column !== want.column)
                        report_mismatch("column", m_column, want.column);
                    if (m_scanline !== want.scanline)
                        report_mismatch("scanline", m_scanline, want.scanline);
                    if (m_pixels !== want.pixels)
                        report_mismatch("pixels", m_pixels, want.pixels);
                    if (m_frame_end !== want.frame_end)
                        report_mismatch("frame_end", m_frame_end, want.frame_end);
                end
                cells_seen++;
            end
            if (cfg_valid && cfg_ready) start_q = cfg_data;
            if (s_valid && s_ready) take_item(s_opcode, s_address, s_data);
        end
        pending_cells  <= cell_queue.size();
        mismatch_count <= fail_tally;
    end

endmodule

>>> dv/tb_character_display_raster_top.sv
// testbench top of the character display raster: stimulus, flow control and verdict
module tb_character_display_raster_top;
    import cdr_pkg::*;

    // opcode that the block takes and drops
    localparam logic [1:0] OP_DROPPED = 2'd3;

    localparam int ADDR_TOP      = (1 << ADDR_W) - 1;
    localparam int START_TOP     = (1 << START_W) - 1;
    localparam int TICK_RUN      = 320;
    localparam int PHASE_ITEMS   = 200;
    localparam int SETTLE_CYCLES = 6;
    // longest quiet stretch: the clearing sweep after reset,
    // or a sender gap on top of a long receiver stall, taken a few times over
    localparam int STALL_LIMIT   = 5000;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_mode_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [START_W-1:0]  cfg_data;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_opcode;
    logic [ADDR_W-1:0]   s_address;
    logic [DATA_W-1:0]   s_data;
    logic                m_valid;
    logic                m_ready;
    logic [COL_W-1:0]    m_column;
    logic [SCAN_W-1:0]   m_scanline;
    logic [GLYPH_W-1:0]  m_pixels;
    logic                m_frame_end;

    int unsigned mismatch_count;
    int unsigned pending_cells;
    int unsigned idle_cycles = 0;
    int unsigned burst_left  = 0;

    character_display_raster_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_address   (s_address),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_column    (m_column),
        .m_scanline  (m_scanline),
        .m_pixels    (m_pixels),
        .m_frame_end (m_frame_end)
    );

    cdr_raster_checker u_raster_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_address      (s_address),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column       (m_column),
        .m_scanline     (m_scanline),
        .m_pixels       (m_pixels),
        .m_frame_end    (m_frame_end),
        .mismatch_count (mismatch_count),
        .pending_cells  (pending_cells)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // result side: switches between open, coin-flip, sparse and comb-shaped
    // ready patterns, each held for a random stretch of cycles
    initial begin : result_sink
        rx_mode_t    mode;
        int unsigned span;
        int unsigned beat;
        m_ready <= 1'b0;
        mode = RX_OPEN;
        span = 0;
        beat = 0;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                span = $urandom_range(24, 400);
            end
            span--;
            beat++;
            case (mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ((beat % 7) < 2);
            endcase
        end
    end

    // watchdog: ends the run when no channel moves an item for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input item; bursts of random length with random gaps between them
    task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        int unsigned gap;
        if (burst_left == 0) begin
            // a third of the bursts follow the last one with no gap at all
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_address <= addr;
        s_data    <= data;
        do @(posedge aclk); while (!s_ready);
    endtask

    // random item: ticks at the given percentage, the rest store writes
    // (some out of range) and the dropped opcode
    task automatic send_random_item(input int unsigned tick_pct, output bit was_tick);
        int unsigned       roll;
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        roll = $urandom_range(0, 99);
        addr = ADDR_W'($urandom_range(0, ADDR_TOP));
        data = DATA_W'($urandom_range(0, 255));
        if (roll < tick_pct) begin
            op = OP_TICK;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                op   = OP_VIDEO_WR;
                addr = ADDR_W'(($urandom_range(0, 9) == 0)
                               ? $urandom_range(VIDEO_SIZE, ADDR_TOP)
                               : $urandom_range(0, VIDEO_SIZE - 1));
            end else if (roll < 90) begin
                op   = OP_GLYPH_WR;
                addr = ADDR_W'(($urandom_range(0, 9) == 0)
                               ? $urandom_range(GLYPH_SIZE, ADDR_TOP)
                               : $urandom_range(0, GLYPH_SIZE - 1));
            end else begin
                op = OP_DROPPED;
            end
        end
        was_tick = (op == OP_TICK);
        send_item(op, addr, data);
    endtask

    // drop valid, wait out every pending cell, then let the pipeline settle
    task automatic drain_cells();
        s_valid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_cells != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_start(input logic [START_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [START_W-1:0] start_plan [0:6];
        bit                 was_tick;
        int unsigned        run_ticks;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_opcode  <= OP_VIDEO_WR;
        s_address <= '0;
        s_data    <= '0;

        start_plan = '{START_W'(VIDEO_SIZE - 1), START_W'(START_TOP), START_W'(VIDEO_SIZE),
                       START_W'($urandom_range(0, VIDEO_SIZE - 1)),
                       START_W'($urandom_range(0, START_TOP)),
                       START_W'(0), START_W'(1)};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // register written once right after reset, during the clearing sweep
        write_start('0);

        // directed: store edges, out-of-range writes, dropped opcode,
        // a first few cells on the blank top line
        send_item(OP_VIDEO_WR, ADDR_W'(0), 8'hff);
        send_item(OP_VIDEO_WR, ADDR_W'(VIDEO_SIZE - 1), 8'h95);
        send_item(OP_VIDEO_WR, ADDR_W'(VIDEO_SIZE), 8'h3f);
        send_item(OP_VIDEO_WR, ADDR_W'(ADDR_TOP), 8'h15);
        send_item(OP_GLYPH_WR, ADDR_W'(0), 8'h81);
        send_item(OP_GLYPH_WR, ADDR_W'(GLYPH_SIZE - 1), 8'hff);
        send_item(OP_GLYPH_WR, ADDR_W'(GLYPH_SIZE), 8'haa);
        send_item(OP_GLYPH_WR, ADDR_W'(ADDR_TOP), 8'h55);
        send_item(OP_GLYPH_WR, ADDR_W'(GLYPH_SIZE - 8), 8'h00);
        send_item(OP_DROPPED, ADDR_W'(ADDR_TOP), 8'hff);
        send_item(OP_DROPPED, ADDR_W'(0), 8'h00);
        send_item(OP_TICK, ADDR_W'(0), 8'h00);
        send_item(OP_TICK, ADDR_W'(ADDR_TOP), 8'hff);
        send_item(OP_TICK, ADDR_W'(0), 8'h00);
        drain_cells();

        // random phases, each under its own display start: the top entry,
        // the widest value, the first value past the store, random ones, zero and one
        foreach (start_plan[p]) begin
            write_start(start_plan[p]);
            repeat (PHASE_ITEMS) send_random_item(50, was_tick);
            drain_cells();
        end

        // a run of mostly ticks so the raster moves on through several lines,
        // with a few writes mixed in
        write_start(START_W'($urandom_range(0, START_TOP)));
        run_ticks = 0;
        while (run_ticks < TICK_RUN) begin
            send_random_item(94, was_tick);
            if (was_tick) run_ticks++;
        end
        drain_cells();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> character_display_raster_top.f
hdl/cdr_pkg.sv
hdl/cdr_video_store.sv
hdl/cdr_glyph_store.sv
hdl/cdr_raster.sv
hdl/character_display_raster_top.sv
dv/cdr_raster_checker.sv
dv/tb_character_display_raster_top.sv
